FILE: rtl/core/touch_gesture_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared concurrent assertion helpers for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tgc_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Event codes, gesture codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgc_pkg;

  localparam int OUT_W = 12;

  // Event classes and codes of the touch controller.
  localparam logic [4:0] EV_TYPE_KEY = 5'd1;
  localparam logic [4:0] EV_TYPE_ABS = 5'd3;
  localparam logic [9:0] AXIS_X      = 10'd0;
  localparam logic [9:0] AXIS_Y      = 10'd1;
  localparam logic [9:0] KEY_TOUCH   = 10'd330;

  // Gesture classes.
  localparam logic [2:0] GEST_TAP   = 3'd0;
  localparam logic [2:0] GEST_RIGHT = 3'd1;
  localparam logic [2:0] GEST_LEFT  = 3'd2;
  localparam logic [2:0] GEST_DOWN  = 3'd3;
  localparam logic [2:0] GEST_UP    = 3'd4;
  localparam logic [2:0] GEST_NONE  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_TAP_LIMIT    = 2'd0;
  localparam logic [1:0] REG_SWIPE_LIMIT  = 2'd1;
  localparam logic [1:0] REG_SCALE_ENABLE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] TAP_LIMIT_RST    = 8'd5;
  localparam logic [9:0] SWIPE_LIMIT_RST  = 10'd50;
  localparam logic       SCALE_ENABLE_RST = 1'b1;

  // Scale factors: X by 800/1024 = 25/32, Y by 480/600 = 4/5.
  // 4/5 is done as c * 52429 >> 16, exact for c below 65536.
  localparam logic [4:0]  X_SCALE_MUL = 5'd25;
  localparam int          X_SCALE_SHR = 5;
  localparam logic [15:0] Y_SCALE_MUL = 16'd52429;
  localparam int          Y_SCALE_SHR = 16;

  typedef struct packed {
    logic [OUT_W-1:0] start_x;
    logic [OUT_W-1:0] start_y;
    logic [OUT_W-1:0] end_x;
    logic [OUT_W-1:0] end_y;
    logic [2:0]       gesture;
    logic [OUT_W-1:0] right_distance;
    logic [OUT_W-1:0] left_distance;
  } result_t;

endpackage

FILE: rtl/core/tgc_classify.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier decision logic
// Classifies a start/end point pair and forms the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgc_classify #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [7:0]            tap_limit,
  input  logic [9:0]            swipe_limit,
  output tgc_pkg::result_t      result
);

  localparam int CW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  is_tap;
  logic                  is_right;
  logic                  is_left;
  logic                  is_down;
  logic                  is_up;
  logic [CW-1:0]         swipe_ext;

  assign dx = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
  assign dy = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
  assign swipe_ext = CW'(swipe_limit);

  assign is_tap   = (dx < COORD_BITS'(tap_limit)) && (dy < COORD_BITS'(tap_limit));
  assign is_right = CW'(end_x) > (CW'(start_x) + swipe_ext);
  assign is_left  = CW'(start_x) > (CW'(end_x) + swipe_ext);
  assign is_down  = CW'(end_y) > (CW'(start_y) + swipe_ext);
  assign is_up    = CW'(start_y) > (CW'(end_y) + swipe_ext);

  always_comb begin
    result.start_x        = tgc_pkg::OUT_W'(start_x);
    result.start_y        = tgc_pkg::OUT_W'(start_y);
    result.end_x          = tgc_pkg::OUT_W'(end_x);
    result.end_y          = tgc_pkg::OUT_W'(end_y);
    result.right_distance = '0;
    result.left_distance  = '0;
    if (is_tap) begin
      result.gesture = tgc_pkg::GEST_TAP;
    end else if (is_right) begin
      result.gesture        = tgc_pkg::GEST_RIGHT;
      result.right_distance = tgc_pkg::OUT_W'(end_x - start_x);
    end else if (is_left) begin
      result.gesture       = tgc_pkg::GEST_LEFT;
      result.left_distance = tgc_pkg::OUT_W'(start_x - end_x);
    end else if (is_down) begin
      result.gesture = tgc_pkg::GEST_DOWN;
    end else if (is_up) begin
      result.gesture = tgc_pkg::GEST_UP;
    end else begin
      result.gesture = tgc_pkg::GEST_NONE;
    end
  end

endmodule

FILE: rtl/core/touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier core
// Turns a stream of touch-screen events into one gesture result per release.
// ----------------------------------------------------------------------------
// Events (type, code, value) enter on the s_ stream and are taken at one per
// clock cycle while the input register is not backed up. A taken event is
// held in the input register; for a release, the result register loads from
// it as it moves on, and that load raises m_tvalid. Absolute X and Y samples
// are clamped to COORD_BITS, scaled to an 800 by 480 screen when
// scale_enable is set, and kept as the latest point; the first X and first Y
// after a release are held as the start point.
// A touch release (key event, touch code, value 0) yields one result with the
// start and end points, the gesture class (tap, right, left, down, up, none,
// tested in that order) and the horizontal swipe distance, and rearms the
// start capture. All other events produce no result. The input register keeps
// accepting while a finished result waits for m_tready. It only backs up when
// it holds a release while the result register is occupied and m_tready is
// low. Configuration writes are always accepted and should be issued only
// while no event is in flight.
`timescale 1ns / 1ps

`include "touch_gesture_classifier_core_defines.svh"

module touch_gesture_classifier_core #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // Event input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: event_type[4:0], event_code[9:0], event_value[11:0],
  // zero fill to 32 bits.
  input  logic [31:0] s_tdata,
  // Result output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: start_x[11:0], start_y[11:0], end_x[11:0],
  // end_y[11:0], gesture[2:0], right_distance[11:0], left_distance[11:0],
  // zero fill to 80 bits.
  output logic [79:0] m_tdata
);

  // Wide enough to hold both a raw 12-bit value and any COORD_BITS value.
  localparam int WIDE = COORD_BITS + 12;
  localparam logic [WIDE-1:0] COORD_MAX = WIDE'((64'd1 << COORD_BITS) - 64'd1);
  localparam int XP_W = COORD_BITS + 5;
  localparam int YP_W = COORD_BITS + 16;

  // Configuration registers.
  logic [7:0] tap_limit;
  logic [9:0] swipe_limit;
  logic       scale_enable;

  // Input register.
  logic        in_valid;
  logic [4:0]  in_type;
  logic [9:0]  in_code;
  logic [11:0] in_value;

  // Touch tracking state.
  logic                  x_latched;
  logic                  y_latched;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] latest_x;
  logic [COORD_BITS-1:0] latest_y;

  // Result register.
  logic             out_valid;
  tgc_pkg::result_t out_data;

  logic                  is_x;
  logic                  is_y;
  logic                  is_release;
  logic                  advance;
  logic [WIDE-1:0]       raw_ext;
  logic [COORD_BITS-1:0] coord;
  logic [XP_W-1:0]       x_prod;
  logic [YP_W-1:0]       y_prod;
  logic [COORD_BITS-1:0] x_val;
  logic [COORD_BITS-1:0] y_val;
  tgc_pkg::result_t      result;

  // ---------------------------------------------------------------------------
  // Configuration port: every write completes in the cycle it is offered.
  // Writes to an index beyond the register list are accepted and dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_limit    <= tgc_pkg::TAP_LIMIT_RST;
      swipe_limit  <= tgc_pkg::SWIPE_LIMIT_RST;
      scale_enable <= tgc_pkg::SCALE_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgc_pkg::REG_TAP_LIMIT:    tap_limit    <= cfg_data[7:0];
        tgc_pkg::REG_SWIPE_LIMIT:  swipe_limit  <= cfg_data;
        tgc_pkg::REG_SCALE_ENABLE: scale_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Event decode on the registered event.
  // ---------------------------------------------------------------------------
  assign is_x = (in_type == tgc_pkg::EV_TYPE_ABS) && (in_code == tgc_pkg::AXIS_X);
  assign is_y = (in_type == tgc_pkg::EV_TYPE_ABS) && (in_code == tgc_pkg::AXIS_Y);
  assign is_release = (in_type == tgc_pkg::EV_TYPE_KEY) &&
                      (in_code == tgc_pkg::KEY_TOUCH) && (in_value == 12'd0);

  // The held event moves on unless it is a release and the result register
  // still holds a result that has not been taken.
  assign advance  = in_valid && (!is_release || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_type  <= s_tdata[4:0];
      in_code  <= s_tdata[14:5];
      in_value <= s_tdata[26:15];
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinate clamp and scaling. X is scaled by 25/32; Y by 4/5 through a
  // reciprocal multiply, which is exact over the whole coordinate range.
  // ---------------------------------------------------------------------------
  assign raw_ext = WIDE'(in_value);
  assign coord   = (raw_ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                         : raw_ext[COORD_BITS-1:0];
  assign x_prod  = XP_W'(coord) * XP_W'(tgc_pkg::X_SCALE_MUL);
  assign y_prod  = YP_W'(coord) * YP_W'(tgc_pkg::Y_SCALE_MUL);
  assign x_val   = scale_enable ? x_prod[tgc_pkg::X_SCALE_SHR +: COORD_BITS] : coord;
  assign y_val   = scale_enable ? y_prod[tgc_pkg::Y_SCALE_SHR +: COORD_BITS] : coord;

  // ---------------------------------------------------------------------------
  // Touch tracking: latest point always follows, the start point is captured
  // once per touch and rearmed by the release.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_latched <= 1'b0;
      y_latched <= 1'b0;
      first_x   <= '0;
      first_y   <= '0;
      latest_x  <= '0;
      latest_y  <= '0;
    end else if (advance) begin
      if (is_x) begin
        latest_x <= x_val;
        if (!x_latched) begin
          first_x   <= x_val;
          x_latched <= 1'b1;
        end
      end
      if (is_y) begin
        latest_y <= y_val;
        if (!y_latched) begin
          first_y   <= y_val;
          y_latched <= 1'b1;
        end
      end
      if (is_release) begin
        x_latched <= 1'b0;
        y_latched <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gesture decision and result register.
  // ---------------------------------------------------------------------------
  tgc_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .start_x     (first_x),
    .start_y     (first_y),
    .end_x       (latest_x),
    .end_y       (latest_y),
    .tap_limit   (tap_limit),
    .swipe_limit (swipe_limit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_release) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_release) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.left_distance, out_data.right_distance,
                     out_data.gesture, out_data.end_y, out_data.end_x,
                     out_data.start_y, out_data.start_x};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `TGC_ASSERT_NOW(a_right_dist_only_right, m_tvalid && (out_data.gesture != tgc_pkg::GEST_RIGHT), out_data.right_distance == '0, "right distance set on a non-right gesture")
  `TGC_ASSERT_NOW(a_left_dist_only_left, m_tvalid && (out_data.gesture != tgc_pkg::GEST_LEFT), out_data.left_distance == '0, "left distance set on a non-left gesture")
  `TGC_ASSERT_NEXT(a_release_rearms, advance && is_release, !x_latched && !y_latched && m_tvalid, "release did not rearm capture or post a result")
  `TGC_ASSERT_NOW(a_stall_only_when_full, !s_tready, in_valid && is_release && m_tvalid && !m_tready, "input stalled without a pending result")

endmodule
